FILE: hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define ASSERT_GATED(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bst_pkg.sv
// Package: types, codes and defaults shared by the bounded set table.
`timescale 1ns / 1ps

package bst_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int CMD_WIDTH    = 2;
   localparam int STATUS_WIDTH = 3;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_INSERT = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_INSERTED   = 3'd0,
      ST_FOUND      = 3'd1,
      ST_ABSENT     = 3'd2,
      ST_FULL       = 3'd3,
      ST_DUPLICATE  = 3'd4,
      ST_CLEARED    = 3'd5,
      ST_LIST_ELEM  = 3'd6,
      ST_LIST_EMPTY = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_LIST = 2'd2
   } state_type;

   // Per-cell control: write the key, or rotate one place toward cell 0.
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

FILE: hdl/bst_if.sv
// Request and response channel interfaces of the bounded set table.
`timescale 1ns / 1ps

interface bst_req_if #(
   parameter int VALUE_WIDTH = bst_pkg::VALUE_WIDTH_DEF
);
   logic                                 valid;
   logic                                 ready;
   logic [bst_pkg::CMD_WIDTH-1:0]        command;
   logic signed [VALUE_WIDTH-1:0]        value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface bst_rsp_if #(
   parameter int VALUE_WIDTH = bst_pkg::VALUE_WIDTH_DEF,
   parameter int COUNT_WIDTH = $clog2(bst_pkg::MAX_ENTRIES_DEF + 1)
);
   logic                                 valid;
   logic                                 ready;
   logic [bst_pkg::STATUS_WIDTH-1:0]     status;
   logic signed [VALUE_WIDTH-1:0]        element;
   logic [COUNT_WIDTH-1:0]               count;
   logic                                 last;

   modport source (output valid, output status, output element, output count,
                   output last, input ready);
   modport sink   (input valid, input status, input element, input count,
                   input last, output ready);
endinterface

FILE: hdl/bst_cell.sv
// One storage cell of the set: holds an element, compares it, rotates it.
`timescale 1ns / 1ps

module bst_cell #(
   parameter int VALUE_WIDTH = bst_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  bst_pkg::cell_ctl_type         ctl,
   input  logic                          in_use,
   input  logic                          wrap,
   input  logic signed [VALUE_WIDTH-1:0] key,
   input  logic signed [VALUE_WIDTH-1:0] next_data,
   input  logic signed [VALUE_WIDTH-1:0] head_data,
   output logic signed [VALUE_WIDTH-1:0] data,
   output logic                          hit
);

   logic signed [VALUE_WIDTH-1:0] data_ff;
   logic signed [VALUE_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = key;
      end else if (ctl.shift) begin
         // the last occupied cell takes the head so the ring closes
         data_in = wrap ? head_data : next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign hit  = in_use && (data_ff == key);

endmodule

FILE: hdl/bounded_set_table.sv
// Top level of the bounded set table: controller and the row of cells.
`timescale 1ns / 1ps

// Bounded set of signed integers kept in insertion order in a row of
// MAX_ENTRIES cells. For insert, query and clear the request is captured
// at its accept edge, and in the next cycle every occupied cell compares
// its element against the value at once and the controller decides; the
// result is registered once the output register is free. A list of an
// empty set answers the same way; for n held elements, after the compare
// cycle the row rotates one place per cycle toward cell 0, cell 0 feeds the
// result, and after n steps the original order is back. One request is
// worked on at a time; the next is accepted in the cycle after the last
// result is loaded into the output register, which may still be waiting
// to be taken. A stalled response side holds the rotation.
module bounded_set_table #(
   parameter int MAX_ENTRIES = bst_pkg::MAX_ENTRIES_DEF,
   parameter int VALUE_WIDTH = bst_pkg::VALUE_WIDTH_DEF,
   parameter int COUNT_WIDTH = $clog2(MAX_ENTRIES + 1)
) (
   input  logic     clock,
   input  logic     reset,
   bst_req_if.sink  req_ch,
   bst_rsp_if.source rsp_ch
);

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(MAX_ENTRIES);
   localparam logic [COUNT_WIDTH-1:0] ONE_COUNT  = COUNT_WIDTH'(1);

   bst_pkg::state_type             state_ff, state_in;
   bst_pkg::cmd_type               cmd_ff, cmd_in;
   logic signed [VALUE_WIDTH-1:0]  key_ff, key_in;
   logic [COUNT_WIDTH-1:0]         fill_ff, fill_in;
   logic [COUNT_WIDTH-1:0]         list_idx_ff, list_idx_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bst_pkg::STATUS_WIDTH-1:0] status_ff, status_in;
   logic signed [VALUE_WIDTH-1:0]  element_ff, element_in;
   logic [COUNT_WIDTH-1:0]         count_ff, count_in;
   logic                           last_ff, last_in;

   logic                           req_fire;
   logic                           out_free;
   logic                           out_load;
   logic                           do_insert;
   logic                           do_shift;
   logic                           any_hit;
   logic                           is_full;
   logic                           list_last;

   logic signed [VALUE_WIDTH-1:0]  cell_data [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]         cell_hit;

   assign req_ch.ready = (state_ff == bst_pkg::S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign any_hit      = |cell_hit;
   assign is_full      = (fill_ff == FULL_COUNT);
   assign list_last    = (list_idx_ff == fill_ff - ONE_COUNT);

   // ---------------------------------------------------------------- cells
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      localparam logic [COUNT_WIDTH-1:0] IDX = COUNT_WIDTH'(i);
      bst_pkg::cell_ctl_type            ctl;
      logic signed [VALUE_WIDTH-1:0]    next_data;

      assign ctl.load  = do_insert && (fill_ff == IDX);
      assign ctl.shift = do_shift;

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign next_data = cell_data[0];
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      bst_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .in_use    (IDX < fill_ff),
         .wrap      (IDX == fill_ff - ONE_COUNT),
         .key       (key_ff),
         .next_data (next_data),
         .head_data (cell_data[0]),
         .data      (cell_data[i]),
         .hit       (cell_hit[i])
      );
   end

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bst_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = bst_pkg::S_EXEC;
            end
         end
         bst_pkg::S_EXEC: begin
            if (cmd_ff == bst_pkg::CMD_LIST && fill_ff != '0) begin
               state_in = bst_pkg::S_LIST;
            end else if (out_free) begin
               state_in = bst_pkg::S_IDLE;
            end
         end
         bst_pkg::S_LIST: begin
            if (out_free && list_last) begin
               state_in = bst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bst_pkg::S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------ datapath control
   always_comb begin
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      fill_in     = fill_ff;
      list_idx_in = list_idx_ff;
      out_load    = 1'b0;
      do_insert   = 1'b0;
      do_shift    = 1'b0;
      status_in   = status_ff;
      element_in  = element_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      case (state_ff)
         bst_pkg::S_IDLE: begin
            if (req_fire) begin
               cmd_in = bst_pkg::cmd_type'(req_ch.command);
               key_in = req_ch.value;
            end
         end
         bst_pkg::S_EXEC: begin
            element_in  = key_ff;
            count_in    = fill_ff;
            last_in     = 1'b1;
            list_idx_in = '0;
            case (cmd_ff)
               bst_pkg::CMD_INSERT: begin
                  out_load = out_free;
                  if (is_full) begin
                     status_in = bst_pkg::ST_FULL;
                  end else if (any_hit) begin
                     status_in = bst_pkg::ST_DUPLICATE;
                  end else begin
                     status_in = bst_pkg::ST_INSERTED;
                     count_in  = fill_ff + ONE_COUNT;
                     do_insert = out_free;
                     if (out_free) begin
                        fill_in = fill_ff + ONE_COUNT;
                     end
                  end
               end
               bst_pkg::CMD_QUERY: begin
                  out_load  = out_free;
                  status_in = any_hit ? bst_pkg::ST_FOUND : bst_pkg::ST_ABSENT;
               end
               bst_pkg::CMD_CLEAR: begin
                  out_load  = out_free;
                  status_in = bst_pkg::ST_CLEARED;
                  count_in  = '0;
                  if (out_free) begin
                     fill_in = '0;
                  end
               end
               bst_pkg::CMD_LIST: begin
                  // a non-empty set is walked in the list state
                  out_load   = out_free && (fill_ff == '0);
                  status_in  = bst_pkg::ST_LIST_EMPTY;
                  element_in = '0;
                  count_in   = '0;
               end
               default: begin
                  out_load = 1'b0;
               end
            endcase
         end
         bst_pkg::S_LIST: begin
            status_in  = bst_pkg::ST_LIST_ELEM;
            element_in = cell_data[0];
            count_in   = fill_ff;
            last_in    = list_last;
            if (out_free) begin
               out_load    = 1'b1;
               do_shift    = 1'b1;
               list_idx_in = list_idx_ff + ONE_COUNT;
            end
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // -------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bst_pkg::S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      list_idx_ff <= list_idx_in;
      if (out_load) begin
         status_ff  <= status_in;
         element_ff <= element_in;
         count_ff   <= count_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = status_ff;
   assign rsp_ch.element = element_ff;
   assign rsp_ch.count   = count_ff;
   assign rsp_ch.last    = last_ff;

endmodule

FILE: hdl/bst_checker.sv
// Port-level checker for the bounded set table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bst_checker #(
   parameter int MAX_ENTRIES = bst_pkg::MAX_ENTRIES_DEF,
   parameter int VALUE_WIDTH = bst_pkg::VALUE_WIDTH_DEF,
   parameter int COUNT_WIDTH = $clog2(MAX_ENTRIES + 1)
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [bst_pkg::STATUS_WIDTH-1:0] rsp_status,
   input logic signed [VALUE_WIDTH-1:0]    rsp_element,
   input logic [COUNT_WIDTH-1:0]           rsp_count,
   input logic                             rsp_last
);

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(MAX_ENTRIES);

   // no response may be pending right after reset
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "response valid after reset")

   // a held response stays valid and keeps its element, status and count
   `ASSERT_GATED(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element) && $stable(rsp_status) && $stable(rsp_count), "stalled response changed")

   // one request at a time: busy right after an accept
   `ASSERT_GATED(a_one_request, clock, reset, req_valid && req_ready |=> !req_ready, "request accepted while busy")

   // every status except a list element closes its request
   `ASSERT_GATED(a_single_last, clock, reset, rsp_valid && rsp_status != bst_pkg::ST_LIST_ELEM |-> rsp_last, "single result without last")

   // the set never reports more elements than it can hold
   `ASSERT_GATED(a_count_range, clock, reset, rsp_valid |-> rsp_count <= FULL_COUNT, "count beyond capacity")

endmodule

bind bounded_set_table bst_checker #(
   .MAX_ENTRIES (MAX_ENTRIES),
   .VALUE_WIDTH (VALUE_WIDTH),
   .COUNT_WIDTH (COUNT_WIDTH)
) u_bst_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_status  (rsp_ch.status),
   .rsp_element (rsp_ch.element),
   .rsp_count   (rsp_ch.count),
   .rsp_last    (rsp_ch.last)
);
